@@ hdl/scpa_pkg.sv @@
package scpa_pkg;

    // Sizing of the allocator.
    localparam int ROUND_BYTES       = 8;
    localparam int MAX_BYTES         = 128;
    localparam int BLOCKS_PER_REFILL = 8;
    localparam int POOL_GRANULES     = 4096;

    localparam int ADDR_W      = 12;
    localparam int LINK_W      = ADDR_W + 1;
    localparam int ADDR_SPACE  = 1 << ADDR_W;
    localparam int POOL_LIMIT  = (POOL_GRANULES < ADDR_SPACE) ? POOL_GRANULES : ADDR_SPACE;
    localparam int NUM_CLASSES = (MAX_BYTES + ROUND_BYTES - 1) / ROUND_BYTES;
    localparam int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int CNT_W       = (BLOCKS_PER_REFILL > 1) ? $clog2(BLOCKS_PER_REFILL) : 1;

    // The shared adder must hold the bump pointer plus one whole refill.
    localparam int NEED_W = $clog2((NUM_CLASSES + 1) * BLOCKS_PER_REFILL + 1);
    localparam int ALU_W  = ((NEED_W > LINK_W) ? NEED_W : LINK_W) + 1;

    // Command codes.
    localparam logic [1:0] CMD_ALLOC    = 2'd0;
    localparam logic [1:0] CMD_FREE     = 2'd1;
    localparam logic [1:0] CMD_FREE_ALL = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOPOOL  = 2'd1;
    localparam logic [1:0] ST_TOOBIG  = 2'd2;
    localparam logic [1:0] ST_BADADDR = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [7:0]        request_bytes;
        logic [ADDR_W-1:0] block_address;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] granted_address;
    } t_out_item;

    typedef enum logic [0:0] {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_REFILL,
        S_POP_RD,
        S_POP,
        S_FREE_HDR,
        S_FREE_RD,
        S_FREE_PUSH,
        S_DONE
    } t_state;

endpackage

@@ hdl/scpa_ram.sv @@
module scpa_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/scpa_alu.sv @@
module scpa_alu
    import scpa_pkg::*;
(
    input  t_alu_req         i_req,
    output logic [ALU_W-1:0] o_result,
    output logic             o_lt
);

    logic [ALU_W:0] sum;
    logic [ALU_W:0] diff;

    // One adder for address stepping and bounds; the subtract borrow is the compare.
    assign sum  = {1'b0, i_req.a} + {1'b0, i_req.b};
    assign diff = {1'b0, i_req.a} - {1'b0, i_req.b};

    always_comb begin
        case (i_req.op)
            ALU_ADD: begin
                o_result = sum[ALU_W-1:0];
                o_lt     = 1'b0;
            end
            ALU_SUB: begin
                o_result = diff[ALU_W-1:0];
                o_lt     = diff[ALU_W];
            end
            default: begin
                o_result = '0;
                o_lt     = 1'b0;
            end
        endcase
    end

endmodule

@@ hdl/size_class_pool_allocator_core.sv @@
// Channel   Direction  Handshake                      Item
// input     in         i_in_valid  / o_in_stall       t_in_item  (cmd, bytes, address)
// output    out        o_out_valid / i_out_stall      t_out_item (status, granted)
//
// Sequence: every accepted item passes S_DECODE, then an allocate that pops S_POP_RD and
// S_POP, a free S_FREE_HDR, S_FREE_RD and S_FREE_PUSH (the last not if its header lies at or
// above the bump pointer), an allocate refused for lack of pool S_CHECK, and the rest none,
// before S_DONE. A refill adds S_REFILL after S_CHECK, one link write per carved block.
// Reset: synchronous, active low; it empties every class stack and zeroes the bump pointer.
// Stalls: the result waits in a register until the output side takes it, the input stays
// stalled until then, and the sequencer returns to S_IDLE before the next item can be accepted.
module size_class_pool_allocator_core
    import scpa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    // Sequencer state and the latched request.
    t_state            r_state, n_state;
    logic [1:0]        r_cmd;
    logic [7:0]        r_bytes;
    logic [ADDR_W-1:0] r_addr_in;

    // Working registers: current class, address walker / header pointer, refill count.
    logic [CLS_W-1:0]  r_cls, n_cls;
    logic [LINK_W-1:0] r_ptr, n_ptr;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [LINK_W-1:0] r_bump, n_bump;

    // Result register.
    logic [1:0]        r_status, n_status;
    logic [ADDR_W-1:0] r_granted, n_granted;

    // Class stack heads: a valid bit per class plus the top header address.
    logic [NUM_CLASSES-1:0] r_head_vld;
    logic [ADDR_W-1:0]      r_head_addr [NUM_CLASSES];
    logic                   head_we;
    logic                   heads_clear;
    logic [CLS_W-1:0]       head_idx;
    logic                   head_wvld;
    logic [ADDR_W-1:0]      head_waddr;

    // Link memory port signals.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [LINK_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [LINK_W-1:0] ram_rdata;

    // Shared adder.
    t_alu_req         alu_req;
    logic [ALU_W-1:0] alu_result;
    logic             alu_lt;

    logic       in_accept;
    logic [7:0] cls_full;
    logic       too_big;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign o_out_item  = '{status: r_status, granted_address: r_granted};

    // Size class: a byte count rounds up to a multiple of the granule, and zero bytes
    // is treated as the smallest class.
    assign cls_full = (r_bytes == 8'd0) ? 8'd0 : 8'((r_bytes - 8'd1) / ROUND_BYTES);
    assign too_big  = (r_bytes > 8'(MAX_BYTES)) || (cls_full >= 8'(NUM_CLASSES));

    scpa_alu u_alu (
        .i_req    (alu_req),
        .o_result (alu_result),
        .o_lt     (alu_lt)
    );

    scpa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (ADDR_SPACE)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bump  <= '0;
        end else begin
            r_state <= n_state;
            r_bump  <= n_bump;
        end
    end

    // Datapath registers carry no reset; the sequencer always loads them before use.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd     <= i_in_item.cmd;
            r_bytes   <= i_in_item.request_bytes;
            r_addr_in <= i_in_item.block_address;
        end
        r_cls     <= n_cls;
        r_ptr     <= n_ptr;
        r_cnt     <= n_cnt;
        r_status  <= n_status;
        r_granted <= n_granted;
    end

    // Head valid bits clear at reset and on free-all.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld <= '0;
        end else if (heads_clear) begin
            r_head_vld <= '0;
        end else if (head_we) begin
            r_head_vld[head_idx] <= head_wvld;
        end
    end

    // An empty head reads as all zeros, since it is copied whole into the first carved
    // header and comes back from there when that block is popped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || heads_clear) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_head_addr[i] <= '0;
            end
        end else if (head_we) begin
            r_head_addr[head_idx] <= head_waddr;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cls       = r_cls;
        n_ptr       = r_ptr;
        n_cnt       = r_cnt;
        n_bump      = r_bump;
        n_status    = r_status;
        n_granted   = r_granted;
        alu_req     = '{op: ALU_ADD, a: '0, b: '0};
        head_we     = 1'b0;
        heads_clear = 1'b0;
        head_idx    = r_cls;
        head_wvld   = 1'b1;
        head_waddr  = r_ptr[ADDR_W-1:0];
        ram_we      = 1'b0;
        ram_waddr   = r_ptr[ADDR_W-1:0];
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = r_ptr[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_status  = ST_OK;
                n_granted = '0;
                case (r_cmd)
                    CMD_ALLOC: begin
                        if (too_big) begin
                            n_status = ST_TOOBIG;
                            n_state  = S_DONE;
                        end else begin
                            n_cls   = cls_full[CLS_W-1:0];
                            n_state = r_head_vld[cls_full[CLS_W-1:0]] ? S_POP_RD : S_CHECK;
                        end
                    end
                    CMD_FREE: begin
                        if (r_addr_in == '0) begin
                            n_status = ST_BADADDR;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_FREE_HDR;
                        end
                    end
                    CMD_FREE_ALL: begin
                        heads_clear = 1'b1;
                        n_bump      = '0;
                        n_state     = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            // The whole refill must fit below the pool limit, or nothing is carved.
            S_CHECK: begin
                alu_req.a = ALU_W'(r_bump);
                alu_req.b = ALU_W'((int'(r_cls) + 2) * BLOCKS_PER_REFILL);
                if (alu_result > ALU_W'(POOL_LIMIT)) begin
                    n_status = ST_NOPOOL;
                    n_state  = S_DONE;
                end else begin
                    n_ptr   = r_bump;
                    n_cnt   = '0;
                    n_state = S_REFILL;
                end
            end

            // One block per cycle, lowest address first: its header links to the old top
            // and it becomes the new top.
            S_REFILL: begin
                ram_we     = 1'b1;
                ram_wdata  = {r_head_vld[r_cls], r_head_addr[r_cls]};
                head_we    = 1'b1;
                alu_req.a  = ALU_W'(r_ptr);
                alu_req.b  = ALU_W'(int'(r_cls) + 2);
                n_ptr      = alu_result[LINK_W-1:0];
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(BLOCKS_PER_REFILL - 1)) begin
                    n_bump  = alu_result[LINK_W-1:0];
                    n_state = S_POP_RD;
                end
            end

            S_POP_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_head_addr[r_cls];
                n_ptr     = {1'b0, r_head_addr[r_cls]};
                n_state   = S_POP;
            end

            // The popped header's link becomes the new head; the header then keeps the
            // class so that a later free knows where to push the block.
            S_POP: begin
                head_we    = 1'b1;
                head_wvld  = ram_rdata[ADDR_W];
                head_waddr = ram_rdata[ADDR_W-1:0];
                ram_we     = 1'b1;
                ram_wdata  = LINK_W'(r_cls);
                alu_req.a  = ALU_W'(r_ptr);
                alu_req.b  = ALU_W'(1);
                n_granted  = alu_result[ADDR_W-1:0];
                n_status   = ST_OK;
                n_state    = S_DONE;
            end

            S_FREE_HDR: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = ALU_W'(r_addr_in);
                alu_req.b  = ALU_W'(1);
                n_ptr      = alu_result[LINK_W-1:0];
                n_state    = S_FREE_RD;
            end

            // The header must lie in the carved part of the pool.
            S_FREE_RD: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = ALU_W'(r_ptr);
                alu_req.b  = ALU_W'(r_bump);
                if (!alu_lt) begin
                    n_status = ST_BADADDR;
                    n_state  = S_DONE;
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_FREE_PUSH;
                end
            end

            // A header that is a link or names no class is not an allocated block.
            S_FREE_PUSH: begin
                if (ram_rdata[ADDR_W] || (ram_rdata[ADDR_W-1:0] >= ADDR_W'(NUM_CLASSES))) begin
                    n_status = ST_BADADDR;
                end else begin
                    head_idx  = ram_rdata[CLS_W-1:0];
                    ram_we    = 1'b1;
                    ram_wdata = {r_head_vld[head_idx], r_head_addr[head_idx]};
                    head_we   = 1'b1;
                    n_status  = ST_OK;
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // No new request may enter while a result waits to be taken.
    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("request accepted while a result is pending");

    // A granted address is reported only by a successful allocation.
    a_grant_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.granted_address != '0)) |-> (o_out_item.status == ST_OK))
        else $error("granted address with non-ok status");

    // Carving never runs past the pool limit.
    a_bump_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bump <= LINK_W'(POOL_LIMIT))
        else $error("bump pointer beyond pool limit");

    // A refill always ends in a pop of the same class.
    a_refill_to_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REFILL && r_cnt == CNT_W'(BLOCKS_PER_REFILL - 1))
            |=> (r_state == S_POP_RD && r_head_vld[r_cls]))
        else $error("refill did not leave a non-empty stack");

    // Every accepted request is worked on in the following cycle.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_DECODE))
        else $error("accepted request not decoded");

endmodule
